@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_SAME(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("check failed: same-cycle implication");

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define CHK_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("check failed: next-cycle implication");

`endif

@@ rtl/bur_pkg.sv @@
package bur_pkg;

    localparam int CMD_W      = 2;
    localparam int INDEX_W    = 10;
    localparam int BYTE_W     = 8;
    localparam int COUNT_W    = 14;
    localparam int LEN_W      = 7;
    localparam int BOUND_W    = 32;
    localparam int VALUE_W    = 64;
    localparam int POS_OUT_W  = 14;

    localparam int MAX_READ_BITS = 64;
    localparam int INT_STEPS     = 32;

    localparam logic [CMD_W-1:0] CMD_LOAD  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_START = 2'd1;
    localparam logic [CMD_W-1:0] CMD_BITS  = 2'd2;
    localparam logic [CMD_W-1:0] CMD_INT   = 2'd3;

    typedef struct packed {
        logic [VALUE_W-1:0]   value;
        logic                 error;
        logic                 at_end;
        logic [POS_OUT_W-1:0] pos_bits;
    } result_t;

endpackage

@@ rtl/bur_store.sv @@
module bur_store #(
    parameter int STORE_BYTES = 1024,
    parameter int ADDR_W      = 10
) (
    input  logic                       aclk,
    input  logic                       we,
    input  logic [ADDR_W-1:0]          waddr,
    input  logic [bur_pkg::BYTE_W-1:0] wdata,
    input  logic [ADDR_W-1:0]          raddr,
    output logic [bur_pkg::BYTE_W-1:0] rdata
);

    logic [bur_pkg::BYTE_W-1:0] mem [STORE_BYTES];
    logic [bur_pkg::BYTE_W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge aclk) begin
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/bur_engine.sv @@
module bur_engine #(
    parameter int STORE_BYTES = 1024,
    parameter int ADDR_W      = 10,
    parameter int POS_W       = 14
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [bur_pkg::CMD_W-1:0]   cmd,
    input  logic [bur_pkg::INDEX_W-1:0] byte_index,
    input  logic [bur_pkg::BYTE_W-1:0]  byte_data,
    input  logic [bur_pkg::COUNT_W-1:0] count_bits,
    input  logic [bur_pkg::LEN_W-1:0]   length,
    input  logic [bur_pkg::BOUND_W-1:0] int_max,
    output logic                        idle,
    output logic                        done,
    input  logic                        out_free,
    output bur_pkg::result_t            result,
    output logic                        mem_we,
    output logic [ADDR_W-1:0]           mem_waddr,
    output logic [bur_pkg::BYTE_W-1:0]  mem_wdata,
    output logic [ADDR_W-1:0]           mem_raddr,
    input  logic [bur_pkg::BYTE_W-1:0]  mem_rdata
);

    localparam int CAP_BITS = STORE_BYTES * bur_pkg::BYTE_W;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_FETCH = 2'd1;
    localparam logic [1:0] ST_SHIFT = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]                   state_reg, state_next;
    logic [POS_W-1:0]             total_reg, total_next;
    logic [POS_W-1:0]             pos_reg, pos_next;
    logic                         ovf_reg, ovf_next;
    logic [bur_pkg::VALUE_W-1:0]  value_reg, value_next;
    logic [bur_pkg::VALUE_W-1:0]  mask_reg, mask_next;
    logic [bur_pkg::LEN_W-1:0]    cnt_reg, cnt_next;
    logic                         is_int_reg, is_int_next;
    logic [bur_pkg::BOUND_W-1:0]  bound_reg, bound_next;

    logic [bur_pkg::BOUND_W:0]    sum;
    logic                         more;
    logic                         cur_bit;
    logic [bur_pkg::LEN_W-1:0]    len_sat;
    logic [POS_W-1:0]             count_sat;

    // The integer read keeps going while value plus the next mask stays under the bound.
    assign sum = {1'b0, value_reg[bur_pkg::BOUND_W-1:0]}
               + {1'b0, mask_reg[bur_pkg::BOUND_W-1:0]};
    assign more = (cnt_reg != '0) && (!is_int_reg || (sum < {1'b0, bound_reg}));
    assign cur_bit = mem_rdata[pos_reg[2:0]];

    assign len_sat = (length > bur_pkg::LEN_W'(bur_pkg::MAX_READ_BITS))
                   ? bur_pkg::LEN_W'(bur_pkg::MAX_READ_BITS) : length;
    assign count_sat = (32'(count_bits) > 32'(CAP_BITS))
                     ? POS_W'(CAP_BITS) : POS_W'(count_bits);

    assign mem_we    = start && (cmd == bur_pkg::CMD_LOAD)
                     && (32'(byte_index) < 32'(STORE_BYTES));
    assign mem_waddr = ADDR_W'(byte_index);
    assign mem_wdata = byte_data;
    assign mem_raddr = ADDR_W'(pos_reg[POS_W-1:3]);

    always_comb begin
        state_next  = state_reg;
        total_next  = total_reg;
        pos_next    = pos_reg;
        ovf_next    = ovf_reg;
        value_next  = value_reg;
        mask_next   = mask_reg;
        cnt_next    = cnt_reg;
        is_int_next = is_int_reg;
        bound_next  = bound_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    value_next = '0;
                    mask_next  = bur_pkg::VALUE_W'(1);
                    unique case (cmd)
                        bur_pkg::CMD_LOAD: begin
                            state_next = ST_DONE;
                        end
                        bur_pkg::CMD_START: begin
                            total_next = count_sat;
                            pos_next   = '0;
                            ovf_next   = 1'b0;
                            state_next = ST_DONE;
                        end
                        bur_pkg::CMD_BITS: begin
                            cnt_next    = len_sat;
                            is_int_next = 1'b0;
                            state_next  = ST_FETCH;
                        end
                        default: begin
                            cnt_next    = bur_pkg::LEN_W'(bur_pkg::INT_STEPS);
                            is_int_next = 1'b1;
                            bound_next  = int_max;
                            state_next  = ST_FETCH;
                        end
                    endcase
                end
            end
            ST_FETCH: begin
                state_next = ST_SHIFT;
            end
            ST_SHIFT: begin
                if (!more) begin
                    state_next = ST_DONE;
                end else begin
                    cnt_next  = cnt_reg - bur_pkg::LEN_W'(1);
                    mask_next = {mask_reg[bur_pkg::VALUE_W-2:0], 1'b0};
                    if (pos_reg >= total_reg) begin
                        ovf_next = 1'b1;
                    end else begin
                        if (cur_bit) begin
                            value_next = value_reg | mask_reg;
                        end
                        pos_next = pos_reg + POS_W'(1);
                        if (pos_reg[2:0] == 3'd7) begin
                            state_next = ST_FETCH;
                        end
                    end
                end
            end
            default: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            total_reg <= '0;
            pos_reg   <= '0;
            ovf_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            total_reg <= total_next;
            pos_reg   <= pos_next;
            ovf_reg   <= ovf_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg  <= value_next;
        mask_reg   <= mask_next;
        cnt_reg    <= cnt_next;
        is_int_reg <= is_int_next;
        bound_reg  <= bound_next;
    end

    assign idle = (state_reg == ST_IDLE);
    assign done = (state_reg == ST_DONE);

    assign result.value    = value_reg;
    assign result.error    = ovf_reg;
    assign result.at_end   = ovf_reg || (pos_reg >= total_reg);
    assign result.pos_bits = bur_pkg::POS_OUT_W'(pos_reg);

endmodule

@@ rtl/bit_unpacker_reader.sv @@
// A load or start item moves the engine to its done state; its result is then registered.
// A read fetches a store byte, then shifts in one bit per cycle, pausing to refetch at each
// byte boundary crossed. One item is in work at a time; the next is accepted once its result
// is registered, and a result held behind a full output register stalls the input.
// Reset (aresetn, synchronous, active low) clears position, bit count, error and the output
// valid flag; the byte store is not cleared and holds garbage until loaded.
module bit_unpacker_reader #(
    parameter int STORE_BYTES = 1024
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [bur_pkg::CMD_W-1:0]   s_cmd,
    input  logic [bur_pkg::INDEX_W-1:0] s_byte_index,
    input  logic [bur_pkg::BYTE_W-1:0]  s_byte_data,
    input  logic [bur_pkg::COUNT_W-1:0] s_count_bits,
    input  logic [bur_pkg::LEN_W-1:0]   s_length,
    input  logic [bur_pkg::BOUND_W-1:0] s_int_max,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [bur_pkg::VALUE_W-1:0] m_value,
    output logic                        m_error,
    output logic                        m_at_end,
    output logic [bur_pkg::POS_OUT_W-1:0] m_pos_bits
);

    // Store address width, and a bit position wide enough to hold the full capacity.
    localparam int ADDR_W = (STORE_BYTES > 1) ? $clog2(STORE_BYTES) : 1;
    localparam int POS_W  = $clog2(STORE_BYTES * bur_pkg::BYTE_W + 1);

    logic                       eng_idle;
    logic                       eng_done;
    logic                       out_free;
    logic                       accept;
    bur_pkg::result_t           eng_result;
    logic                       mem_we;
    logic [ADDR_W-1:0]          mem_waddr;
    logic [bur_pkg::BYTE_W-1:0] mem_wdata;
    logic [ADDR_W-1:0]          mem_raddr;
    logic [bur_pkg::BYTE_W-1:0] mem_rdata;

    logic                       m_valid_reg, m_valid_next;
    bur_pkg::result_t           m_data_reg;

    // The engine takes a new item whenever it is idle; a finished result may still
    // be waiting in the output register at that time.
    assign s_ready  = eng_idle;
    assign accept   = s_valid && s_ready;
    assign out_free = !m_valid_reg || m_ready;

    bur_store #(
        .STORE_BYTES (STORE_BYTES),
        .ADDR_W      (ADDR_W)
    ) u_store (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    bur_engine #(
        .STORE_BYTES (STORE_BYTES),
        .ADDR_W      (ADDR_W),
        .POS_W       (POS_W)
    ) u_engine (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .start      (accept),
        .cmd        (s_cmd),
        .byte_index (s_byte_index),
        .byte_data  (s_byte_data),
        .count_bits (s_count_bits),
        .length     (s_length),
        .int_max    (s_int_max),
        .idle       (eng_idle),
        .done       (eng_done),
        .out_free   (out_free),
        .result     (eng_result),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .mem_rdata  (mem_rdata)
    );

    // Output register: it is refilled when the engine finishes and the slot is free.
    always_comb begin
        m_valid_next = m_valid_reg;
        if (eng_done && out_free) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (eng_done && out_free) begin
            m_data_reg <= eng_result;
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_value    = m_data_reg.value;
    assign m_error    = m_data_reg.error;
    assign m_at_end   = m_data_reg.at_end;
    assign m_pos_bits = m_data_reg.pos_bits;

endmodule

@@ rtl/bur_checker.sv @@
`include "assert_macros.svh"

module bur_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [bur_pkg::VALUE_W-1:0]   m_value,
    input logic                          m_error,
    input logic                          m_at_end
);

    // A held result must not change until it is taken.
    `CHK_NEXT(a_out_hold, aclk, aresetn, m_valid && !m_ready, m_valid && $stable(m_value))

    // The overrun flag always implies the end-of-packet indication.
    `CHK_SAME(a_err_at_end, aclk, aresetn, m_valid && m_error, m_at_end)

    // Only one item is in work: after an item is taken the input closes.
    `CHK_NEXT(a_one_item, aclk, aresetn, s_valid && s_ready, !s_ready)

    // A fresh result appears exactly when the engine goes back to idle.
    `CHK_SAME(a_done_idle, aclk, aresetn, $rose(m_valid), s_ready)

endmodule

bind bit_unpacker_reader bur_checker u_bur_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_value  (m_value),
    .m_error  (m_error),
    .m_at_end (m_at_end)
);
